// ----- hdl/skts_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted key table package
// Shared sizes, action and result codes, and the result record.
// ----------------------------------------------------------------------------
package skts_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_BYTES   = 8;
    localparam int MAX_RESULTS = 12;

    localparam int KEY_W = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int PRB_W = $clog2(MAX_RESULTS);

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LINEAR = 2'd1,
        ACT_BINARY = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_PROBE  = 2'd1,
        KIND_RESULT = 2'd2,
        KIND_READ   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  position;
        logic [KEY_W-1:0]  entry_key;
        logic              found;
        logic              table_full;
        logic [CNT_W-1:0]  entry_count;
        logic              last;
    } t_result;

endpackage

// ----- hdl/skts_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with enable; read data is registered and
// holds while the read enable is low.
// ----------------------------------------------------------------------------
module skts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/sorted_key_table_search_top.sv -----
// ----------------------------------------------------------------------------
// Sorted key table search, top level
// Ascending key table in one RAM with insert, linear search, binary search
// and entry read, all run by a small sequencer around one compare unit.
// ----------------------------------------------------------------------------
// Sequence: insert walks down from the top entry, shifting each greater
// entry up; linear search reads up from entry 0 to the first match or the
// count; binary search reads one midpoint per probe; read fetches one entry.
// Throughput: one transaction at a time; o_ready is high only while idle.
// Reset (synchronous, active low) clears the count and the output valid;
// table contents are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module sorted_key_table_search_top #(
    parameter int KEY_BYTES = skts_pkg::KEY_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_action,
    input  logic [skts_pkg::KEY_W-1:0]  i_key,
    input  logic [skts_pkg::IDX_W-1:0]  i_entry_index,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_kind,
    output logic [skts_pkg::IDX_W-1:0]  o_position,
    output logic [skts_pkg::KEY_W-1:0]  o_entry_key,
    output logic                        o_found,
    output logic                        o_table_full,
    output logic [skts_pkg::CNT_W-1:0]  o_entry_count,
    output logic                        o_last
);

    localparam int KEY_W = skts_pkg::KEY_W;
    localparam int IDX_W = skts_pkg::IDX_W;
    localparam int CNT_W = skts_pkg::CNT_W;
    localparam int PRB_W = skts_pkg::PRB_W;

    // Keep only the top KEY_BYTES bytes of a key; the rest reads as zero.
    localparam logic [KEY_W-1:0] KeyMask = ~({KEY_W{1'b1}} >> (8 * KEY_BYTES));

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FULL  = 8'b0000_0010,
        S_INS   = 8'b0000_0100,
        S_LIN   = 8'b0000_1000,
        S_BADDR = 8'b0001_0000,
        S_BDATA = 8'b0010_0000,
        S_BHIT  = 8'b0100_0000,
        S_READ  = 8'b1000_0000
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;   // keys held
    logic [KEY_W-1:0]       r_key,   n_key;     // masked key of this transaction
    logic [CNT_W-1:0]       r_idx,   n_idx;     // walk pointer / probe position
    logic [CNT_W-1:0]       r_low,   n_low;     // binary search lower bound
    logic [CNT_W-1:0]       r_hix,   n_hix;     // binary search upper bound, exclusive
    logic [PRB_W-1:0]       r_probes, n_probes; // probes reported so far
    skts_pkg::t_result      r_res,   n_res;     // output register
    logic                   r_o_valid, n_o_valid;

    // RAM port signals
    logic                   w_we;
    logic [IDX_W-1:0]       w_waddr;
    logic [KEY_W-1:0]       w_wdata;
    logic                   w_re;
    logic [IDX_W-1:0]       w_raddr;
    logic [KEY_W-1:0]       w_rdata;

    // Shared datapath
    logic                   w_slot_free;
    logic                   w_emit;
    skts_pkg::t_result      w_emit_res;
    logic [CNT_W-1:0]       w_idx_dec, w_idx_dm2, w_idx_inc, w_cnt_dec, w_cnt_inc;
    logic [CNT_W:0]         w_mid_sum;
    logic [CNT_W-1:0]       w_mid;
    logic                   w_eq, w_gt, w_lt;
    logic                   w_report;

    assign w_idx_dec = r_idx - CNT_W'(1);
    assign w_idx_dm2 = r_idx - CNT_W'(2);
    assign w_idx_inc = r_idx + CNT_W'(1);
    assign w_cnt_dec = r_count - CNT_W'(1);
    assign w_cnt_inc = r_count + CNT_W'(1);

    // Midpoint rounded up: (low + high + 1) / 2 with high = hix - 1.
    assign w_mid_sum = {1'b0, r_low} + {1'b0, r_hix};
    assign w_mid     = w_mid_sum[CNT_W:1];

    // The one key comparator, shared by insert, linear and binary search.
    assign w_eq = (w_rdata == r_key);
    assign w_gt = (w_rdata >  r_key);
    assign w_lt = (w_rdata <  r_key);

    assign w_report    = (r_probes < PRB_W'(skts_pkg::MAX_RESULTS - 1));
    assign w_slot_free = !r_o_valid || i_ready;

    skts_ram #(
        .WIDTH (KEY_W),
        .DEPTH (skts_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_key      = r_key;
        n_idx      = r_idx;
        n_low      = r_low;
        n_hix      = r_hix;
        n_probes   = r_probes;
        w_we       = 1'b0;
        w_waddr    = r_idx[IDX_W-1:0];
        w_wdata    = r_key;
        w_re       = 1'b0;
        w_raddr    = '0;
        w_emit     = 1'b0;
        w_emit_res = r_res;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_key = i_key & KeyMask;
                    case (skts_pkg::t_action'(i_action))
                        skts_pkg::ACT_INSERT: begin
                            if (r_count >= CNT_W'(skts_pkg::TABLE_DEPTH)) begin
                                n_state = S_FULL;
                            end else begin
                                // Start the walk down from the top entry.
                                n_idx   = r_count;
                                w_re    = 1'b1;
                                w_raddr = w_cnt_dec[IDX_W-1:0];
                                n_state = S_INS;
                            end
                        end
                        skts_pkg::ACT_LINEAR: begin
                            n_idx   = '0;
                            w_re    = 1'b1;
                            w_raddr = '0;
                            n_state = S_LIN;
                        end
                        skts_pkg::ACT_BINARY: begin
                            n_low    = '0;
                            n_hix    = r_count;
                            n_probes = '0;
                            n_state  = S_BADDR;
                        end
                        default: begin
                            n_idx   = CNT_W'(i_entry_index);
                            w_re    = 1'b1;
                            w_raddr = i_entry_index;
                            n_state = S_READ;
                        end
                    endcase
                end
            end

            S_FULL: begin
                // Drop the key and flag the full table.
                if (w_slot_free) begin
                    w_emit                 = 1'b1;
                    w_emit_res.kind        = skts_pkg::KIND_INSERT;
                    w_emit_res.position    = '0;
                    w_emit_res.entry_key   = r_key;
                    w_emit_res.found       = 1'b0;
                    w_emit_res.table_full  = 1'b1;
                    w_emit_res.entry_count = r_count;
                    w_emit_res.last        = 1'b1;
                    n_state                = S_IDLE;
                end
            end

            S_INS: begin
                // Read data holds entry r_idx - 1.
                if ((r_idx != '0) && w_gt) begin
                    // Shift the greater entry up and fetch the next one down.
                    w_we    = 1'b1;
                    w_wdata = w_rdata;
                    n_idx   = w_idx_dec;
                    w_re    = 1'b1;
                    w_raddr = w_idx_dm2[IDX_W-1:0];
                end else if (w_slot_free) begin
                    w_we                   = 1'b1;
                    w_wdata                = r_key;
                    n_count                = w_cnt_inc;
                    w_emit                 = 1'b1;
                    w_emit_res.kind        = skts_pkg::KIND_INSERT;
                    w_emit_res.position    = r_idx[IDX_W-1:0];
                    w_emit_res.entry_key   = r_key;
                    w_emit_res.found       = 1'b0;
                    w_emit_res.table_full  = 1'b0;
                    w_emit_res.entry_count = w_cnt_inc;
                    w_emit_res.last        = 1'b1;
                    n_state                = S_IDLE;
                end
            end

            S_LIN: begin
                // Read data holds entry r_idx.
                if (r_idx >= r_count) begin
                    if (w_slot_free) begin
                        w_emit                 = 1'b1;
                        w_emit_res.kind        = skts_pkg::KIND_RESULT;
                        w_emit_res.position    = '0;
                        w_emit_res.entry_key   = '0;
                        w_emit_res.found       = 1'b0;
                        w_emit_res.table_full  = 1'b0;
                        w_emit_res.entry_count = r_count;
                        w_emit_res.last        = 1'b1;
                        n_state                = S_IDLE;
                    end
                end else if (w_eq) begin
                    if (w_slot_free) begin
                        w_emit                 = 1'b1;
                        w_emit_res.kind        = skts_pkg::KIND_RESULT;
                        w_emit_res.position    = r_idx[IDX_W-1:0];
                        w_emit_res.entry_key   = w_rdata;
                        w_emit_res.found       = 1'b1;
                        w_emit_res.table_full  = 1'b0;
                        w_emit_res.entry_count = r_count;
                        w_emit_res.last        = 1'b1;
                        n_state                = S_IDLE;
                    end
                end else begin
                    n_idx   = w_idx_inc;
                    w_re    = 1'b1;
                    w_raddr = w_idx_inc[IDX_W-1:0];
                end
            end

            S_BADDR: begin
                if (r_low < r_hix) begin
                    n_idx   = w_mid;
                    w_re    = 1'b1;
                    w_raddr = w_mid[IDX_W-1:0];
                    n_state = S_BDATA;
                end else if (w_slot_free) begin
                    // Range empty: report the miss.
                    w_emit                 = 1'b1;
                    w_emit_res.kind        = skts_pkg::KIND_RESULT;
                    w_emit_res.position    = '0;
                    w_emit_res.entry_key   = '0;
                    w_emit_res.found       = 1'b0;
                    w_emit_res.table_full  = 1'b0;
                    w_emit_res.entry_count = r_count;
                    w_emit_res.last        = 1'b1;
                    n_state                = S_IDLE;
                end
            end

            S_BDATA: begin
                // Hold while a reportable probe waits for the output slot.
                if (!w_report || w_slot_free) begin
                    if (w_report) begin
                        w_emit                 = 1'b1;
                        w_emit_res.kind        = skts_pkg::KIND_PROBE;
                        w_emit_res.position    = r_idx[IDX_W-1:0];
                        w_emit_res.entry_key   = w_rdata;
                        w_emit_res.found       = w_eq;
                        w_emit_res.table_full  = 1'b0;
                        w_emit_res.entry_count = r_count;
                        w_emit_res.last        = 1'b0;
                        n_probes               = r_probes + PRB_W'(1);
                    end
                    if (w_eq) begin
                        n_state = S_BHIT;
                    end else begin
                        if (w_lt) begin
                            n_low = w_idx_inc;
                        end else begin
                            n_hix = r_idx;
                        end
                        n_state = S_BADDR;
                    end
                end
            end

            S_BHIT: begin
                if (w_slot_free) begin
                    w_emit                 = 1'b1;
                    w_emit_res.kind        = skts_pkg::KIND_RESULT;
                    w_emit_res.position    = r_idx[IDX_W-1:0];
                    w_emit_res.entry_key   = w_rdata;
                    w_emit_res.found       = 1'b1;
                    w_emit_res.table_full  = 1'b0;
                    w_emit_res.entry_count = r_count;
                    w_emit_res.last        = 1'b1;
                    n_state                = S_IDLE;
                end
            end

            S_READ: begin
                if (w_slot_free) begin
                    w_emit                 = 1'b1;
                    w_emit_res.kind        = skts_pkg::KIND_READ;
                    w_emit_res.position    = r_idx[IDX_W-1:0];
                    w_emit_res.found       = (r_idx < r_count);
                    w_emit_res.entry_key   = (r_idx < r_count) ? w_rdata : '0;
                    w_emit_res.table_full  = 1'b0;
                    w_emit_res.entry_count = r_count;
                    w_emit_res.last        = 1'b1;
                    n_state                = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: load on emit, drop valid once taken.
    always_comb begin
        n_res     = r_res;
        n_o_valid = r_o_valid;
        if (w_emit) begin
            n_res     = w_emit_res;
            n_o_valid = 1'b1;
        end else if (i_ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_low    <= n_low;
        r_hix    <= n_hix;
        r_probes <= n_probes;
        r_res    <= n_res;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_kind        = r_res.kind;
    assign o_position    = r_res.position;
    assign o_entry_key   = r_res.entry_key;
    assign o_found       = r_res.found;
    assign o_table_full  = r_res.table_full;
    assign o_entry_count = r_res.entry_count;
    assign o_last        = r_res.last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // The count never exceeds the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(skts_pkg::TABLE_DEPTH))
        else $error("key count above table depth");

    // Only a completed insert changes the count.
    a_count_from_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> ($past(r_state) == S_INS))
        else $error("key count changed outside insert");

    // The table is written only during an insert.
    a_write_in_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_INS))
        else $error("table write outside insert");

    // Binary search bounds never cross.
    a_bounds_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BADDR) |-> (r_low <= r_hix))
        else $error("binary search bounds crossed");

endmodule

// ----- test/sorted_key_table_search_top_tb.sv -----
// ----------------------------------------------------------------------------
// Sorted key table search testbench
// Drives insert, linear search, binary search and read transactions through
// valid/ready, predicts every result from a local copy of the table and
// compares each result field by field. Runs directed corners on an empty and
// a small table, then random mixes under three idle patterns.
// ----------------------------------------------------------------------------
module sorted_key_table_search_top_tb;

    localparam int KEY_W       = skts_pkg::KEY_W;
    localparam int IDX_W       = skts_pkg::IDX_W;
    localparam int CNT_W       = skts_pkg::CNT_W;
    localparam int TABLE_DEPTH = skts_pkg::TABLE_DEPTH;
    localparam int KEY_BYTES   = skts_pkg::KEY_BYTES;
    localparam int MAX_RESULTS = skts_pkg::MAX_RESULTS;

    localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
    // Only the top KEY_BYTES bytes of a key take part; the rest reads as zero.
    localparam logic [KEY_W-1:0] KEY_MASK = ~(KEY_ONES >> (8 * KEY_BYTES));
    localparam int unsigned SETTLE_CYCLES = TABLE_DEPTH + 64;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_action;
    logic [KEY_W-1:0]   i_key;
    logic [IDX_W-1:0]   i_entry_index;
    logic               o_valid;
    logic               i_ready;
    logic [1:0]         o_kind;
    logic [IDX_W-1:0]   o_position;
    logic [KEY_W-1:0]   o_entry_key;
    logic               o_found;
    logic               o_table_full;
    logic [CNT_W-1:0]   o_entry_count;
    logic               o_last;

    // Local copy of the table state and the results still owed by the block.
    logic [KEY_W-1:0]   table_copy [TABLE_DEPTH];
    int unsigned        held_keys;
    skts_pkg::t_result  owed_results [$];

    int unsigned        error_count;
    int unsigned        send_idle_pct;
    int unsigned        recv_idle_pct;

    sorted_key_table_search_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_entry_index (i_entry_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_position    (o_position),
        .o_entry_key   (o_entry_key),
        .o_found       (o_found),
        .o_table_full  (o_table_full),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Error reporting: one line per mismatch, and every mismatch is counted.
    // ------------------------------------------------------------------------
    task automatic report_error(input string msg);
        error_count++;
        $display("%0t ERROR %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Result prediction
    // ------------------------------------------------------------------------
    // Build one result record; entry_count always reflects the table after
    // this transaction has been applied.
    function automatic skts_pkg::t_result make_result(skts_pkg::t_kind kind,
                                                      int unsigned pos,
                                                      logic [KEY_W-1:0] k, logic hit,
                                                      logic full, logic fin);
        skts_pkg::t_result r;
        r.kind        = kind;
        r.position    = IDX_W'(pos);
        r.entry_key   = k;
        r.found       = hit;
        r.table_full  = full;
        r.entry_count = CNT_W'(held_keys);
        r.last        = fin;
        return r;
    endfunction

    // Apply one accepted transaction to the table copy and queue the results
    // the block owes for it.
    function automatic void predict_table_op(skts_pkg::t_action act,
                                             logic [KEY_W-1:0] raw_key,
                                             logic [IDX_W-1:0] idx);
        logic [KEY_W-1:0] k;
        int               lo;
        int               hi;
        int               mid;
        int               probes;
        int unsigned      pos;
        logic             hit;

        k   = raw_key & KEY_MASK;
        hit = 1'b0;
        pos = 0;
        case (act)
            skts_pkg::ACT_INSERT: begin
                if (held_keys >= TABLE_DEPTH) begin
                    owed_results.push_back(make_result(skts_pkg::KIND_INSERT, 0, k,
                                                       1'b0, 1'b1, 1'b1));
                end else begin
                    // Shift strictly greater keys up; equal keys stay in front.
                    pos = held_keys;
                    while (pos > 0 && table_copy[pos-1] > k) begin
                        table_copy[pos] = table_copy[pos-1];
                        pos--;
                    end
                    table_copy[pos] = k;
                    held_keys++;
                    owed_results.push_back(make_result(skts_pkg::KIND_INSERT, pos, k,
                                                       1'b0, 1'b0, 1'b1));
                end
            end
            skts_pkg::ACT_LINEAR: begin
                for (int unsigned i = 0; i < held_keys; i++) begin
                    if (!hit && table_copy[i] == k) begin
                        hit = 1'b1;
                        pos = i;
                    end
                end
                if (hit) begin
                    owed_results.push_back(make_result(skts_pkg::KIND_RESULT, pos,
                                                       table_copy[pos], 1'b1, 1'b0, 1'b1));
                end else begin
                    owed_results.push_back(make_result(skts_pkg::KIND_RESULT, 0, '0,
                                                       1'b0, 1'b0, 1'b1));
                end
            end
            skts_pkg::ACT_BINARY: begin
                lo     = 0;
                hi     = int'(held_keys) - 1;
                probes = 0;
                while (lo <= hi) begin
                    // Midpoint rounds up.
                    mid = (lo + hi + 1) / 2;
                    // Probes past the room left for the final result go unreported.
                    if (probes < MAX_RESULTS - 1) begin
                        owed_results.push_back(make_result(skts_pkg::KIND_PROBE, mid,
                                                           table_copy[mid],
                                                           table_copy[mid] == k,
                                                           1'b0, 1'b0));
                        probes++;
                    end
                    if (table_copy[mid] == k) begin
                        hit = 1'b1;
                        pos = mid;
                        break;
                    end else if (table_copy[mid] < k) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid - 1;
                    end
                end
                if (hit) begin
                    owed_results.push_back(make_result(skts_pkg::KIND_RESULT, pos,
                                                       table_copy[pos], 1'b1, 1'b0, 1'b1));
                end else begin
                    owed_results.push_back(make_result(skts_pkg::KIND_RESULT, 0, '0,
                                                       1'b0, 1'b0, 1'b1));
                end
            end
            default: begin
                if (idx < held_keys) begin
                    owed_results.push_back(make_result(skts_pkg::KIND_READ, idx,
                                                       table_copy[idx], 1'b1, 1'b0, 1'b1));
                end else begin
                    owed_results.push_back(make_result(skts_pkg::KIND_READ, idx, '0,
                                                       1'b0, 1'b0, 1'b1));
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result channel: random back-pressure, driven at the falling edge.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check every result transaction against the oldest owed result.
    always @(posedge i_clk) begin
        skts_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (owed_results.size() == 0) begin
                report_error($sformatf("result with none pending: kind %0d pos %0d key %h",
                                       o_kind, o_position, o_entry_key));
            end else begin
                want = owed_results.pop_front();
                if (o_kind !== want.kind)
                    report_error($sformatf("kind: got %0d, expected %0d", o_kind, want.kind));
                if (o_position !== want.position)
                    report_error($sformatf("position: got %0d, expected %0d",
                                           o_position, want.position));
                if (o_entry_key !== want.entry_key)
                    report_error($sformatf("entry_key: got %h, expected %h",
                                           o_entry_key, want.entry_key));
                if (o_found !== want.found)
                    report_error($sformatf("found: got %b, expected %b", o_found, want.found));
                if (o_table_full !== want.table_full)
                    report_error($sformatf("table_full: got %b, expected %b",
                                           o_table_full, want.table_full));
                if (o_entry_count !== want.entry_count)
                    report_error($sformatf("entry_count: got %0d, expected %0d",
                                           o_entry_count, want.entry_count));
                if (o_last !== want.last)
                    report_error($sformatf("last: got %b, expected %b", o_last, want.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input channel
    // ------------------------------------------------------------------------
    // Send one transaction. Called at a falling edge; returns at a falling
    // edge with valid low. Idle gaps are drawn before valid is raised, then
    // valid and payload hold until the block takes the transaction.
    task automatic send_table_op(input skts_pkg::t_action act,
                                 input logic [KEY_W-1:0] k,
                                 input logic [IDX_W-1:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_action      = act;
        i_key         = k;
        i_entry_index = idx;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        predict_table_op(act, k, idx);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Hold the sender until every owed result has come back.
    task automatic wait_for_results();
        while (owed_results.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Pack a short string left-aligned into a key, zero padded.
    function automatic logic [KEY_W-1:0] pack_key(input string s);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < s.len() && i < KEY_W / 8; i++) begin
            k[KEY_W-1-8*i -: 8] = s[i];
        end
        return k;
    endfunction

    // Draw a key biased toward collisions: keys already held, their
    // neighbors, a tiny alphabet of short strings, the extremes, and fully
    // random values so every key bit toggles.
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        int unsigned      sel;
        int unsigned      len;
        sel = $urandom_range(0, 9);
        if (held_keys == 0 && (sel <= 3 || sel == 8)) begin
            sel = 6;
        end
        k = '0;
        case (sel)
            0, 1, 2, 3: k = table_copy[$urandom_range(0, held_keys - 1)];
            4, 5: begin
                len = $urandom_range(1, 3);
                for (int unsigned j = 0; j < len; j++) begin
                    k[KEY_W-1-8*j -: 8] = 8'h61 + 8'($urandom_range(0, 3));
                end
            end
            6, 7: k = {$urandom, $urandom};
            8: begin
                k = table_copy[$urandom_range(0, held_keys - 1)];
                k = $urandom_range(0, 1) ? k + 1'b1 : k - 1'b1;
            end
            default: k = $urandom_range(0, 1) ? KEY_ONES : '0;
        endcase
        return k;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Searches and reads on an empty table: misses, the lone final result of
    // a binary search, reads out of range at both index extremes.
    task automatic test_empty_table();
        send_table_op(skts_pkg::ACT_LINEAR, pack_key("a"), '0);
        send_table_op(skts_pkg::ACT_BINARY, pack_key("a"), '0);
        send_table_op(skts_pkg::ACT_READ, '0, '0);
        send_table_op(skts_pkg::ACT_READ, '0, {IDX_W{1'b1}});
    endtask

    // Inserts at both key extremes, a full eight-byte key, a duplicate that
    // must land after its twin, and keys that land in the middle.
    task automatic test_insert_order();
        send_table_op(skts_pkg::ACT_INSERT, '0, '0);
        send_table_op(skts_pkg::ACT_INSERT, KEY_ONES, '0);
        send_table_op(skts_pkg::ACT_INSERT, pack_key("b"), '0);
        send_table_op(skts_pkg::ACT_INSERT, pack_key("b"), {IDX_W{1'b1}});
        send_table_op(skts_pkg::ACT_INSERT, pack_key("a"), '0);
        send_table_op(skts_pkg::ACT_INSERT, pack_key("abcdefgh"), '0);
        send_table_op(skts_pkg::ACT_INSERT, pack_key("ba"), '0);
    endtask

    // Hits, first-of-duplicate, the all-zero key, misses, then reads at the
    // first, last and first-invalid positions.
    task automatic test_search_and_read();
        send_table_op(skts_pkg::ACT_LINEAR, pack_key("b"), '0);
        send_table_op(skts_pkg::ACT_LINEAR, '0, '0);
        send_table_op(skts_pkg::ACT_LINEAR, pack_key("c"), '0);
        send_table_op(skts_pkg::ACT_BINARY, KEY_ONES, '0);
        send_table_op(skts_pkg::ACT_BINARY, '0, '0);
        send_table_op(skts_pkg::ACT_BINARY, pack_key("b"), '0);
        send_table_op(skts_pkg::ACT_BINARY, pack_key("c"), '0);
        send_table_op(skts_pkg::ACT_READ, '0, '0);
        send_table_op(skts_pkg::ACT_READ, '0, IDX_W'(held_keys - 1));
        send_table_op(skts_pkg::ACT_READ, KEY_ONES, IDX_W'(held_keys));
    endtask

    // Random mix of all four actions. Halfway through, and now and then at
    // random, hold the sender until the block has drained.
    task automatic test_random_mix(input int unsigned n_items);
        int unsigned       r;
        skts_pkg::t_action act;
        logic [IDX_W-1:0]  idx;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i == n_items / 2 || $urandom_range(0, 24) == 0) begin
                wait_for_results();
            end
            r   = $urandom_range(0, 99);
            act = (r < 35) ? skts_pkg::ACT_INSERT : (r < 55) ? skts_pkg::ACT_LINEAR :
                  (r < 80) ? skts_pkg::ACT_BINARY : skts_pkg::ACT_READ;
            // Reads mostly land inside the table; the rest cover all indexes.
            if (held_keys > 0 && $urandom_range(0, 4) != 0) begin
                idx = IDX_W'($urandom_range(0, held_keys - 1));
            end else begin
                idx = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
            end
            send_table_op(act, pick_key(), idx);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_action      = skts_pkg::ACT_INSERT;
        i_key         = '0;
        i_entry_index = '0;
        i_ready       = 1'b0;
        held_keys     = 0;
        error_count   = 0;
        send_idle_pct = 13;
        recv_idle_pct = 67;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Sender mostly busy, receiver stalling hard.
        test_empty_table();
        test_insert_order();
        test_search_and_read();
        test_random_mix(60);

        // Swap the idle pattern: sparse sender, eager receiver.
        send_idle_pct = 67;
        recv_idle_pct = 13;
        test_random_mix(70);

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(60);

        // Drain, then keep the clock running so any stray result shows before
        // the verdict.
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("sorted_key_table_search_top_tb: clean");
        end else begin
            $display("sorted_key_table_search_top_tb: errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #30000000;
        $display("sorted_key_table_search_top_tb: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/skts_pkg.sv
hdl/skts_ram.sv
hdl/sorted_key_table_search_top.sv
test/sorted_key_table_search_top_tb.sv
